>>> rtl/soil_column_heat_diffusion_unit_defines.svh
// Assertion macros used by the soil column heat diffusion sequencer.
`ifndef SOIL_COLUMN_HEAT_DIFFUSION_UNIT_DEFINES_SVH
`define SOIL_COLUMN_HEAT_DIFFUSION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk, ignored while aresetn is low.
`define SCDH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scdh: same-cycle check failed");

// Next-cycle implication, sampled on aclk, ignored while aresetn is low.
`define SCDH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scdh: next-cycle check failed");

`endif

>>> rtl/scdh_pkg.sv
// Shared types, constants and the microcode program of the soil column unit.
`default_nettype none
package scdh_pkg;

    localparam int unsigned LAYERS  = 8;
    localparam int unsigned LAYER_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam logic [LAYER_W-1:0] LAYER_LAST = LAYER_W'(LAYERS - 1);

    localparam logic [31:0]        RESET_DIFFUSION_GAIN = 32'd65536;
    localparam logic [31:0]        RESET_STEP_GAIN      = 32'd65536;
    localparam logic signed [31:0] RESET_INITIAL_TEMP   = 32'sd19660800;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_TEMP   = 2'd2;

    localparam int unsigned PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_WAIT  = 4'd0;
    localparam pc_t PC_ABS_T = 4'd1;
    localparam pc_t PC_MUL_D = 4'd2;
    localparam pc_t PC_RND_F = 4'd3;
    localparam pc_t PC_ABS_F = 4'd4;
    localparam pc_t PC_MUL_S = 4'd5;
    localparam pc_t PC_RND_I = 4'd6;
    localparam pc_t PC_UPD   = 4'd7;
    localparam pc_t PC_SX1   = 4'd8;
    localparam pc_t PC_SX2   = 4'd9;
    localparam pc_t PC_INIT  = 4'd10;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ABS_T,
        OP_MUL_D,
        OP_RND_F,
        OP_ABS_F,
        OP_MUL_S,
        OP_RND_I,
        OP_UPD,
        OP_SX1,
        OP_SX2,
        OP_INIT
    } op_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_WAIT_IN,
        JMP_LOOP,
        JMP_WAIT_OUT
    } jmp_t;

    typedef struct packed {
        op_t  op;
        jmp_t jmp;
        pc_t  target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic last;
    } ctrl_t;

    typedef struct packed {
        logic [31:0]        diffusion_gain;
        logic [31:0]        step_gain;
        logic signed [31:0] initial_temp;
    } cfg_t;

    // The program: one pass of steps one to seven per layer, or the initialization,
    // then the surface extrapolation and the result beat.
    function automatic uword_t ucode_rom(input pc_t pc);
        uword_t w;
        w = '{op: OP_NOP, jmp: JMP_ALWAYS, target: PC_WAIT};
        unique case (pc)
            PC_WAIT:  w = '{op: OP_LOAD,  jmp: JMP_WAIT_IN,  target: PC_INIT};
            PC_ABS_T: w = '{op: OP_ABS_T, jmp: JMP_NEXT,     target: PC_WAIT};
            PC_MUL_D: w = '{op: OP_MUL_D, jmp: JMP_NEXT,     target: PC_WAIT};
            PC_RND_F: w = '{op: OP_RND_F, jmp: JMP_NEXT,     target: PC_WAIT};
            PC_ABS_F: w = '{op: OP_ABS_F, jmp: JMP_NEXT,     target: PC_WAIT};
            PC_MUL_S: w = '{op: OP_MUL_S, jmp: JMP_NEXT,     target: PC_WAIT};
            PC_RND_I: w = '{op: OP_RND_I, jmp: JMP_NEXT,     target: PC_WAIT};
            PC_UPD:   w = '{op: OP_UPD,   jmp: JMP_LOOP,     target: PC_ABS_T};
            PC_SX1:   w = '{op: OP_SX1,   jmp: JMP_NEXT,     target: PC_WAIT};
            PC_SX2:   w = '{op: OP_SX2,   jmp: JMP_WAIT_OUT, target: PC_WAIT};
            PC_INIT:  w = '{op: OP_INIT,  jmp: JMP_ALWAYS,   target: PC_SX1};
            default:  w = '{op: OP_NOP,   jmp: JMP_ALWAYS,   target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

>>> rtl/scdh_cfg_regs.sv
// Configuration register file: diffusion gain, step gain and initial temperature.
`default_nettype none
module scdh_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [scdh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data,
    output scdh_pkg::cfg_t                      cfg
);

    scdh_pkg::cfg_t cfg_reg;
    scdh_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Writes to an index beyond the register list are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                scdh_pkg::REG_DIFFUSION_GAIN: cfg_next.diffusion_gain = cfg_data;
                scdh_pkg::REG_STEP_GAIN:      cfg_next.step_gain      = cfg_data;
                scdh_pkg::REG_INITIAL_TEMP:   cfg_next.initial_temp   = cfg_data;
                default:                      cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.diffusion_gain <= scdh_pkg::RESET_DIFFUSION_GAIN;
            cfg_reg.step_gain      <= scdh_pkg::RESET_STEP_GAIN;
            cfg_reg.initial_temp   <= scdh_pkg::RESET_INITIAL_TEMP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/scdh_sequencer.sv
// Microcode sequencer: step counter, layer counter, jumps and the channel handshakes.
`default_nettype none
`include "soil_column_heat_diffusion_unit_defines.svh"
module scdh_sequencer (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire logic      s_action,
    output logic           m_valid,
    input  wire logic      m_ready,
    output scdh_pkg::ctrl_t ctrl
);

    scdh_pkg::pc_t                   pc_reg;
    scdh_pkg::pc_t                   pc_next;
    logic [scdh_pkg::LAYER_W-1:0]    lcnt_reg;
    logic [scdh_pkg::LAYER_W-1:0]    lcnt_next;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    scdh_pkg::uword_t                uword;
    logic                            go;
    logic                            last;

    assign uword   = scdh_pkg::ucode_rom(pc_reg);
    assign last    = (lcnt_reg == scdh_pkg::LAYER_LAST);
    assign s_ready = (pc_reg == scdh_pkg::PC_WAIT);
    assign m_valid = m_valid_reg;

    always_comb begin
        pc_next      = pc_reg;
        lcnt_next    = lcnt_reg;
        m_valid_next = m_valid_reg;
        go           = 1'b1;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (uword.jmp)
            scdh_pkg::JMP_NEXT: begin
                pc_next = pc_reg + scdh_pkg::PC_W'(1);
            end
            scdh_pkg::JMP_ALWAYS: begin
                pc_next = uword.target;
            end
            scdh_pkg::JMP_WAIT_IN: begin
                go = s_valid;
                if (s_valid) begin
                    pc_next = s_action ? pc_reg + scdh_pkg::PC_W'(1) : uword.target;
                end
            end
            scdh_pkg::JMP_LOOP: begin
                pc_next = last ? pc_reg + scdh_pkg::PC_W'(1) : uword.target;
            end
            scdh_pkg::JMP_WAIT_OUT: begin
                // The result register may still hold the previous beat.
                go = !m_valid_reg || m_ready;
                if (go) begin
                    pc_next      = uword.target;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                pc_next = scdh_pkg::PC_WAIT;
            end
        endcase
        if (go && uword.op == scdh_pkg::OP_UPD) begin
            lcnt_next = last ? '0 : lcnt_reg + scdh_pkg::LAYER_W'(1);
        end
        ctrl.op   = go ? uword.op : scdh_pkg::OP_NOP;
        ctrl.last = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= scdh_pkg::PC_WAIT;
            lcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            lcnt_reg    <= lcnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `SCDH_ASSERT_SAME(a_pc_in_program, 1'b1, pc_reg <= scdh_pkg::PC_INIT)
    `SCDH_ASSERT_NEXT(a_init_branch, s_valid && s_ready && !s_action, pc_reg == scdh_pkg::PC_INIT)
    `SCDH_ASSERT_NEXT(a_loop_wraps, pc_reg == scdh_pkg::PC_UPD && last, lcnt_reg == '0 && pc_reg == scdh_pkg::PC_SX1)
    `SCDH_ASSERT_NEXT(a_result_shown, pc_reg == scdh_pkg::PC_SX2 && go, m_valid_reg && pc_reg == scdh_pkg::PC_WAIT)

endmodule
`default_nettype wire

>>> rtl/scdh_datapath.sv
// Datapath: rotating layer line, shared gain multiplier, rounding and result registers.
`default_nettype none
module scdh_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire scdh_pkg::ctrl_t     ctrl,
    input  wire scdh_pkg::cfg_t      cfg,
    input  wire logic signed [31:0]  s_surface_flux,
    output logic signed [31:0]       m_surface_temp,
    output logic signed [31:0]       m_top_layer_temp
);

    // Product of a magnitude and a gain, rounded to nearest with ties away
    // from zero, then given its sign and saturated to 32 bits.
    function automatic logic signed [31:0] round_sat(input logic [63:0] prod, input logic neg);
        logic [48:0] p;
        p = 49'((65'(prod) + 65'h8000) >> 16);
        if (neg) begin
            if (p >= 49'h80000000) return 32'h80000000;
            return 32'(~p[31:0] + 32'd1);
        end
        if (p > 49'h7FFFFFFF) return 32'h7FFFFFFF;
        return p[31:0];
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) return v[32] ? 32'h80000000 : 32'h7FFFFFFF;
        return v[31:0];
    endfunction

    // The layer being worked on always sits in tap 0; each update rotates the line by one, so
    // after a full pass the layers are back in their home taps.
    logic signed [31:0] ring_reg  [scdh_pkg::LAYERS];
    logic signed [31:0] ring_next [scdh_pkg::LAYERS];
    logic signed [31:0] flux_above_reg, flux_above_next;
    logic signed [31:0] flux_below_reg, flux_below_next;
    logic signed [31:0] inc_reg, inc_next;
    logic [31:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [63:0]        prod_reg, prod_next;
    logic signed [33:0] sv_reg, sv_next;
    logic signed [31:0] surf_reg, surf_next;
    logic signed [31:0] top_reg, top_next;

    logic signed [31:0] below;
    logic signed [32:0] diff;
    logic [31:0]        gain;
    logic signed [31:0] rnd;
    logic signed [33:0] t0x;
    logic signed [33:0] t1x;
    logic signed [33:0] rsum;

    assign m_surface_temp   = surf_reg;
    assign m_top_layer_temp = top_reg;

    always_comb begin
        below = ctrl.last ? cfg.initial_temp : ring_reg[1];
        if (ctrl.op == scdh_pkg::OP_ABS_T) begin
            diff = 33'(ring_reg[0]) - 33'(below);
        end else begin
            diff = 33'(flux_above_reg) - 33'(flux_below_reg);
        end
        gain = (ctrl.op == scdh_pkg::OP_MUL_D) ? cfg.diffusion_gain : cfg.step_gain;
        rnd  = round_sat(prod_reg, neg_reg);
        t0x  = 34'(ring_reg[0]);
        t1x  = 34'(ring_reg[1]);
        rsum = sv_reg + $signed({33'd0, ~sv_reg[33]});

        ring_next       = ring_reg;
        flux_above_next = flux_above_reg;
        flux_below_next = flux_below_reg;
        inc_next        = inc_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        sv_next         = sv_reg;
        surf_next       = surf_reg;
        top_next        = top_reg;

        unique case (ctrl.op)
            scdh_pkg::OP_NOP: begin
            end
            scdh_pkg::OP_LOAD: begin
                flux_above_next = s_surface_flux;
            end
            scdh_pkg::OP_ABS_T, scdh_pkg::OP_ABS_F: begin
                neg_next = diff[32];
                mag_next = diff[32] ? 32'(-diff) : diff[31:0];
            end
            scdh_pkg::OP_MUL_D, scdh_pkg::OP_MUL_S: begin
                prod_next = 64'(mag_reg) * 64'(gain);
            end
            scdh_pkg::OP_RND_F: begin
                flux_below_next = rnd;
            end
            scdh_pkg::OP_RND_I: begin
                inc_next = rnd;
            end
            scdh_pkg::OP_UPD: begin
                for (int k = 0; k < scdh_pkg::LAYERS - 1; k++) begin
                    ring_next[k] = ring_reg[k+1];
                end
                ring_next[scdh_pkg::LAYERS-1] = sat33(33'(ring_reg[0]) + 33'(inc_reg));
                flux_above_next = flux_below_reg;
            end
            scdh_pkg::OP_SX1: begin
                sv_next = (t0x <<< 1) + t0x - t1x;
            end
            scdh_pkg::OP_SX2: begin
                // Halving rounds ties away from zero: add one first when positive.
                surf_next = sat33(rsum[33:1]);
                top_next  = ring_reg[0];
            end
            scdh_pkg::OP_INIT: begin
                for (int k = 0; k < scdh_pkg::LAYERS; k++) begin
                    ring_next[k] = cfg.initial_temp;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < scdh_pkg::LAYERS; k++) begin
                ring_reg[k] <= scdh_pkg::RESET_INITIAL_TEMP;
            end
        end else begin
            ring_reg <= ring_next;
        end
    end

    always_ff @(posedge aclk) begin
        flux_above_reg <= flux_above_next;
        flux_below_reg <= flux_below_next;
        inc_reg        <= inc_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        prod_reg       <= prod_next;
        sv_reg         <= sv_next;
        surf_reg       <= surf_next;
        top_reg        <= top_next;
    end

endmodule
`default_nettype wire

>>> rtl/soil_column_heat_diffusion_unit.sv
// Soil column heat diffusion unit: top level.
// Keeps one column of LAYERS soil temperatures (signed Q16.16) and advances it by an
// explicit diffusion step, or resets it to the initial temperature, once per input beat;
// each input beat yields one result beat with the extrapolated surface temperature and
// the top layer temperature. A small microprogram drives one shared 32x32 multiplier, and
// each layer takes seven steps through it (difference, multiply, round for the interface
// flux, then the same for the layer increment, then the update), then extrapolates the
// surface temperature; an initialization sets every layer to the initial temperature and
// extrapolates likewise. The input is ready again in the cycle the result appears.
// Items are worked one at a time; a finished result waits in its output register while
// the next input beat is taken, and the next result is held back until that one is
// accepted. Configuration writes take effect at once and should be made while the unit
// is idle.
`default_nettype none
module soil_column_heat_diffusion_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_action,
    input  wire logic signed [31:0]             s_surface_flux,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [31:0]                  m_surface_temp,
    output logic signed [31:0]                  m_top_layer_temp,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [scdh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    scdh_pkg::cfg_t  cfg;
    scdh_pkg::ctrl_t ctrl;

    scdh_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    scdh_sequencer u_sequencer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .ctrl     (ctrl)
    );

    scdh_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (ctrl),
        .cfg              (cfg),
        .s_surface_flux   (s_surface_flux),
        .m_surface_temp   (m_surface_temp),
        .m_top_layer_temp (m_top_layer_temp)
    );

endmodule
`default_nettype wire

>>> tb/sv/tb_soil_column_heat_diffusion_unit.sv
// Testbench for the soil column heat diffusion unit: column predictor and randomized traffic.
`timescale 1ns / 100ps

module tb_soil_column_heat_diffusion_unit;

    localparam logic ACT_INIT = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // The index field has room for one register that does not exist.
    localparam logic [scdh_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic signed [31:0] I32_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] I32_MIN    = 32'sh8000_0000;
    localparam logic signed [63:0] I32_MAX_64 = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN_64 = -64'sd2147483648;

    localparam int SETTLE_CYCLES = 80;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 122;

    typedef struct packed {
        logic               action;
        logic signed [31:0] flux;
    } column_cmd_t;

    typedef struct packed {
        logic signed [31:0] surface_temp;
        logic signed [31:0] top_layer_temp;
    } column_reading_t;

    logic                                aclk           = 1'b0;
    logic                                aresetn        = 1'b0;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic                                s_action       = ACT_INIT;
    logic signed [31:0]                  s_surface_flux = '0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic signed [31:0]                  m_surface_temp;
    logic signed [31:0]                  m_top_layer_temp;
    logic                                cfg_valid      = 1'b0;
    logic                                cfg_ready;
    logic [scdh_pkg::CFG_IDX_W-1:0]      cfg_index      = '0;
    logic [31:0]                         cfg_data       = '0;

    soil_column_heat_diffusion_unit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_surface_flux   (s_surface_flux),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_surface_temp   (m_surface_temp),
        .m_top_layer_temp (m_top_layer_temp),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Predicted column state and register copies.
    logic [31:0]        col_diff_gain = scdh_pkg::RESET_DIFFUSION_GAIN;
    logic [31:0]        col_step_gain = scdh_pkg::RESET_STEP_GAIN;
    logic signed [31:0] col_init_temp = scdh_pkg::RESET_INITIAL_TEMP;
    logic signed [31:0] layer_t   [scdh_pkg::LAYERS];
    logic signed [31:0] face_flux [scdh_pkg::LAYERS];

    column_cmd_t     pending_cmds[$];
    column_reading_t expected_readings[$];

    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    logic idle_on  = 1'b1;
    int   tx_gap   = 0;
    int   rx_wait  = 0;
    int   cycles   = 0;
    int   readings_checked = 0;
    int   mismatches  = 0;
    int   unexpected  = 0;
    int   steps_seen  = 0;
    int   inits_seen  = 0;
    int   reg_writes  = 0;
    int   settings    = 0;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > I32_MAX_64) return I32_MAX;
        if (v < I32_MIN_64) return I32_MIN;
        return v[31:0];
    endfunction

    // Unsigned Q16.16 gain times a signed difference, rounded half away from zero.
    function automatic logic signed [31:0] scale_by_gain(input logic [31:0] gain,
                                                         input logic signed [63:0] d);
        logic        neg;
        logic [63:0] mag;
        logic [95:0] prod;
        logic [95:0] q;
        neg  = d < 0;
        mag  = neg ? -d : d;
        prod = mag * gain + 96'h8000;
        q    = prod >> 16;
        if (neg) begin
            if (q >= 96'h8000_0000) return I32_MIN;
            return -$signed(q[31:0]);
        end
        if (q > 96'h7FFF_FFFF) return I32_MAX;
        return q[31:0];
    endfunction

    function automatic column_reading_t advance_column(input logic action,
                                                       input logic signed [31:0] flux);
        column_reading_t    r;
        logic signed [63:0] t0, t1, below, upper, v, q;
        logic signed [31:0] inc;
        if (action == ACT_INIT) begin
            for (int i = 0; i < scdh_pkg::LAYERS; i++) begin
                layer_t[i]   = col_init_temp;
                face_flux[i] = '0;
            end
        end else begin
            for (int i = 0; i < scdh_pkg::LAYERS; i++) begin
                t0 = layer_t[i];
                if (i + 1 < scdh_pkg::LAYERS) below = layer_t[i + 1];
                else below = col_init_temp;
                face_flux[i] = scale_by_gain(col_diff_gain, t0 - below);
            end
            for (int i = 0; i < scdh_pkg::LAYERS; i++) begin
                if (i == 0) upper = flux;
                else upper = face_flux[i - 1];
                t0  = face_flux[i];
                inc = scale_by_gain(col_step_gain, upper - t0);
                t0  = layer_t[i];
                layer_t[i] = clamp32(t0 + inc);
            end
        end
        t0 = layer_t[0];
        t1 = layer_t[1];
        v  = 3 * t0 - t1;
        if (v >= 0) q = (v + 1) / 2;
        else q = -((-v + 1) / 2);
        r.surface_temp   = clamp32(q);
        r.top_layer_temp = layer_t[0];
        return r;
    endfunction

    function automatic logic signed [31:0] draw_flux();
        unique case ($urandom_range(0, 3))
            0: return $urandom;
            1, 2: return int'($urandom_range(0, 2621440)) - 1310720;
            default: begin
                unique case ($urandom_range(0, 4))
                    0: return I32_MIN;
                    1: return I32_MAX;
                    2: return -1;
                    3: return 1;
                    default: return 0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] draw_gain();
        unique case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            5: return 32'h0001_0000;
            default: return $urandom_range(0, 32'h8000);
        endcase
    endfunction

    function automatic logic signed [31:0] draw_temp();
        unique case ($urandom_range(0, 5))
            0: return $urandom;
            1: return I32_MIN;
            2: return I32_MAX;
            default: return int'($urandom_range(0, 6553600)) - 3276800;
        endcase
    endfunction

    task automatic queue_cmd(input logic action, input logic signed [31:0] flux);
        pending_cmds.push_back('{action: action, flux: flux});
    endtask

    task automatic write_reg(input logic [scdh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        unique case (idx)
            scdh_pkg::REG_DIFFUSION_GAIN: col_diff_gain = val;
            scdh_pkg::REG_STEP_GAIN:      col_step_gain = val;
            scdh_pkg::REG_INITIAL_TEMP:   col_init_temp = val;
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_column_regs(input logic [31:0] dg, input logic [31:0] sg,
                                   input logic signed [31:0] it);
        write_reg(scdh_pkg::REG_DIFFUSION_GAIN, dg);
        write_reg(scdh_pkg::REG_STEP_GAIN, sg);
        write_reg(scdh_pkg::REG_INITIAL_TEMP, it);
        settings++;
    endtask

    // Wait until every queued item has been taken and every result checked.
    task automatic settle_column();
        do @(posedge aclk);
        while (pending_cmds.size() != 0 || s_valid || expected_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, expected_readings.size());
            $display("[soil_column_heat_diffusion_unit] ERROR");
            $finish;
        end
    end

    // Monitor: check the result beat first, then predict the input beat.
    always @(posedge aclk) begin
        column_reading_t want;
        in_fire  = aresetn && s_valid && s_ready;
        out_fire = aresetn && m_valid && m_ready;
        if (out_fire) begin
            if (expected_readings.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("Unexpected result: surface %0d top %0d",
                             m_surface_temp, m_top_layer_temp);
            end else begin
                want = expected_readings.pop_front();
                if (m_surface_temp !== want.surface_temp ||
                    m_top_layer_temp !== want.top_layer_temp) begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display({"Result %0d: expected surface %0d top %0d, ",
                                  "got surface %0d top %0d"},
                                 readings_checked, want.surface_temp, want.top_layer_temp,
                                 m_surface_temp, m_top_layer_temp);
                end
            end
            readings_checked++;
        end
        if (in_fire) begin
            expected_readings.push_back(advance_column(s_action, s_surface_flux));
            if (s_action == ACT_INIT) inits_seen++;
            else steps_seen++;
        end
    end

    // Driver: a beat stays on the bus until it is taken.
    always @(negedge aclk) begin
        column_cmd_t cmd;
        if (!(s_valid && !in_fire)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                cmd = pending_cmds.pop_front();
                s_valid        <= 1'b1;
                s_action       <= cmd.action;
                s_surface_flux <= cmd.flux;
                tx_gap = idle_on ? $urandom_range(0, 7) : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: short random stalls in most phases, and two long holds so the input backs up.
    always @(negedge aclk) begin
        if (out_fire) begin
            if (readings_checked == 200 || readings_checked == 700) rx_wait = LONG_HOLD;
            else rx_wait = idle_on ? $urandom_range(0, 7) : 0;
        end
        if (rx_wait > 0) begin
            rx_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        int failures;
        for (int i = 0; i < scdh_pkg::LAYERS; i++) begin
            layer_t[i]   = scdh_pkg::RESET_INITIAL_TEMP;
            face_flux[i] = '0;
        end
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Reset values: steps straight from reset, flux extremes, then saturation both ways.
        settings++;
        queue_cmd(ACT_STEP, 0);
        queue_cmd(ACT_STEP, I32_MAX);
        queue_cmd(ACT_STEP, I32_MIN);
        queue_cmd(ACT_STEP, -1);
        queue_cmd(ACT_STEP, 1);
        queue_cmd(ACT_INIT, I32_MAX);
        repeat (3) queue_cmd(ACT_STEP, I32_MAX);
        queue_cmd(ACT_INIT, -1);
        repeat (3) queue_cmd(ACT_STEP, I32_MIN);
        queue_cmd(ACT_INIT, 0);
        settle_column();

        // Largest gains, and a bottom value changed without a new initialization.
        set_column_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, I32_MAX);
        queue_cmd(ACT_STEP, I32_MIN);
        queue_cmd(ACT_STEP, I32_MAX);
        queue_cmd(ACT_INIT, 0);
        queue_cmd(ACT_STEP, 0);
        settle_column();

        // Zero gains leave the column frozen; the unused index must change nothing.
        set_column_regs(32'h0, 32'h0, I32_MIN);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        queue_cmd(ACT_STEP, I32_MAX);
        queue_cmd(ACT_INIT, I32_MIN);
        queue_cmd(ACT_STEP, I32_MIN);
        settle_column();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_column_regs(draw_gain(), draw_gain(), draw_temp());
            if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
            idle_on = (p % 3) != 2;
            if ($urandom_range(0, 1) == 1) queue_cmd(ACT_INIT, draw_flux());
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 24) == 0) queue_cmd(ACT_INIT, draw_flux());
                else queue_cmd(ACT_STEP, draw_flux());
            end
            settle_column();
        end

        failures = mismatches + unexpected + expected_readings.size();
        $display("Covered %0d time steps and %0d initializations under %0d register settings",
                 steps_seen, inits_seen, settings);
        $display("(%0d register writes); %0d results checked, %0d mismatches, %0d unexpected.",
                 reg_writes, readings_checked, mismatches, unexpected);
        if (failures == 0) begin
            $display("[soil_column_heat_diffusion_unit] OK");
        end else begin
            $display("[soil_column_heat_diffusion_unit] ERROR");
        end
        $finish;
    end

endmodule
